### sv/stse_pkg.sv
`default_nettype none
package stse_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int TIME_W      = 32;
   localparam int SIZE_W      = 20;
   localparam int TOTAL_W     = 24;
   localparam int COUNT_W     = 5;

   localparam logic [TOTAL_W-1:0] CAPACITY_RESET = 24'd32768;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TRIM   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_INSERTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_EVICTED  = 2'd2,
      KIND_DONE     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic              operation;
      logic [TIME_W-1:0] entry_time;
      logic [SIZE_W-1:0] entry_size;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [TIME_W-1:0]  out_time;
      logic [SIZE_W-1:0]  out_size;
      logic [TOTAL_W-1:0] total_size;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_payload_type;

endpackage
`default_nettype wire

### sv/stse_if.sv
`default_nettype none
interface stse_req_if;
   logic                      valid;
   logic                      ready;
   stse_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface stse_rsp_if;
   logic                      valid;
   logic                      ready;
   stse_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface stse_csr_if;
   logic                              valid;
   logic                              ready;
   logic [stse_pkg::TOTAL_W-1:0]      data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/stse_ram.sv
`default_nettype none
module stse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### sv/sorted_table_with_size_eviction.sv
`default_nettype none
// Insert: entries not older than the new one move up, then the result; rejects skip the move.
// Trim: per eviction a min scan over held entries and its report, then entries above move down
//   to close the gap; a done item ends it. Results wait for an output slot. One item at a time.
// The table RAM (one read, one write port) sets the pace: one entry per cycle.
// Reset: synchronous, active high; clears count, total, FSM and output valid,
//   capacity returns to 32768. Table contents are not cleared.
module sorted_table_with_size_eviction (
   input wire logic  clock,
   input wire logic  reset,
   stse_req_if.sink  req_if,
   stse_rsp_if.source rsp_if,
   stse_csr_if.sink  csr_if
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_START,
      ST_INS_LOOP,
      ST_INS_LAST,
      ST_TRIM_CHK,
      ST_SCAN,
      ST_EVICT,
      ST_SHIFT_START,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   state_type ret_state_ff, ret_state_in;

   logic [stse_pkg::TOTAL_W-1:0] capacity_ff, capacity_in;
   stse_pkg::cnt_type            count_ff, count_in;
   logic [stse_pkg::TOTAL_W-1:0] total_ff, total_in;

   // item being inserted
   logic [stse_pkg::TIME_W-1:0]  new_time_ff, new_time_in;
   logic [stse_pkg::SIZE_W-1:0]  new_size_ff, new_size_in;

   // walking pointer for insert and compaction, scan index, running minimum
   stse_pkg::idx_type            ptr_ff, ptr_in;
   stse_pkg::idx_type            scan_idx_ff, scan_idx_in;
   stse_pkg::idx_type            min_idx_ff, min_idx_in;
   logic [stse_pkg::SIZE_W-1:0]  min_size_ff, min_size_in;
   logic [stse_pkg::TIME_W-1:0]  min_time_ff, min_time_in;

   // pending result, handed to the output register in ST_EMIT
   stse_pkg::kind_type           res_kind_ff, res_kind_in;
   logic [stse_pkg::TIME_W-1:0]  res_time_ff, res_time_in;
   logic [stse_pkg::SIZE_W-1:0]  res_size_ff, res_size_in;
   logic                         res_last_ff, res_last_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   stse_pkg::rsp_payload_type    rsp_data_ff, rsp_data_in;

   // table RAM
   logic                         wr_en;
   stse_pkg::idx_type            wr_addr;
   stse_pkg::entry_type          wr_data;
   stse_pkg::idx_type            rd_addr;
   stse_pkg::entry_type          rd_data;

   logic [stse_pkg::TOTAL_W:0]   ins_sum;
   stse_pkg::entry_type          new_entry;

   assign ins_sum   = {1'b0, total_ff} + {{(stse_pkg::TOTAL_W - stse_pkg::SIZE_W + 1){1'b0}},
                                          req_if.data.entry_size};
   assign new_entry = '{stamp: new_time_ff, size: new_size_ff};

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   stse_ram #(
      .WIDTH ($bits(stse_pkg::entry_type)),
      .DEPTH (stse_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      ret_state_in = ret_state_ff;
      capacity_in  = capacity_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      new_time_in  = new_time_ff;
      new_size_in  = new_size_ff;
      ptr_in       = ptr_ff;
      scan_idx_in  = scan_idx_ff;
      min_idx_in   = min_idx_ff;
      min_size_in  = min_size_ff;
      min_time_in  = min_time_ff;
      res_kind_in  = res_kind_ff;
      res_time_in  = res_time_ff;
      res_size_in  = res_size_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;

      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = new_entry;
      rd_addr = '0;

      if (csr_if.valid) begin
         capacity_in = csr_if.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               new_time_in = req_if.data.entry_time;
               new_size_in = req_if.data.entry_size;
               res_time_in = '0;
               res_size_in = '0;
               res_last_in = 1'b1;
               if (req_if.data.operation == stse_pkg::OP_TRIM) begin
                  state_in = ST_TRIM_CHK;
               end else if (count_ff == stse_pkg::cnt_type'(stse_pkg::TABLE_DEPTH) ||
                            ins_sum[stse_pkg::TOTAL_W]) begin
                  // full table or total would wrap: nothing changes
                  res_kind_in  = stse_pkg::KIND_REJECTED;
                  ret_state_in = ST_IDLE;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_INS_START;
               end
            end
         end

         // insert walks down from the top, moving up every entry not older than the new one
         ST_INS_START: begin
            if (count_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               state_in = ST_INS_LAST;
            end else begin
               rd_addr  = stse_pkg::idx_type'(count_ff - stse_pkg::cnt_type'(1));
               ptr_in   = rd_addr;
               state_in = ST_INS_LOOP;
            end
         end

         ST_INS_LOOP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + stse_pkg::idx_type'(1);
            if (rd_data.stamp >= new_time_ff) begin
               wr_data = rd_data;
               if (ptr_ff == '0) begin
                  state_in = ST_INS_LAST;
               end else begin
                  rd_addr = ptr_ff - stse_pkg::idx_type'(1);
                  ptr_in  = rd_addr;
               end
            end else begin
               // slot found above an older entry: new entry written here
               count_in     = count_ff + stse_pkg::cnt_type'(1);
               total_in     = total_ff + stse_pkg::TOTAL_W'(new_size_ff);
               res_kind_in  = stse_pkg::KIND_INSERTED;
               ret_state_in = ST_IDLE;
               state_in     = ST_EMIT;
            end
         end

         ST_INS_LAST: begin
            // entry 0 gets the new item unless it was already written on an empty table
            if (count_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = '0;
            end
            count_in     = count_ff + stse_pkg::cnt_type'(1);
            total_in     = total_ff + stse_pkg::TOTAL_W'(new_size_ff);
            res_kind_in  = stse_pkg::KIND_INSERTED;
            ret_state_in = ST_IDLE;
            state_in     = ST_EMIT;
         end

         ST_TRIM_CHK: begin
            if (total_ff > capacity_ff && count_ff != '0) begin
               rd_addr     = '0;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end else begin
               res_kind_in  = stse_pkg::KIND_DONE;
               res_time_in  = '0;
               res_size_in  = '0;
               res_last_in  = 1'b1;
               ret_state_in = ST_IDLE;
               state_in     = ST_EMIT;
            end
         end

         // one entry per cycle; strict less-than keeps the earliest of equal sizes
         ST_SCAN: begin
            if (scan_idx_ff == '0 || rd_data.size < min_size_ff) begin
               min_idx_in  = scan_idx_ff;
               min_size_in = rd_data.size;
               min_time_in = rd_data.stamp;
            end
            if ({1'b0, scan_idx_ff} + stse_pkg::CNT_W'(1) < count_ff) begin
               rd_addr     = scan_idx_ff + stse_pkg::idx_type'(1);
               scan_idx_in = rd_addr;
            end else begin
               state_in = ST_EVICT;
            end
         end

         ST_EVICT: begin
            count_in     = count_ff - stse_pkg::cnt_type'(1);
            total_in     = total_ff - stse_pkg::TOTAL_W'(min_size_ff);
            res_kind_in  = stse_pkg::KIND_EVICTED;
            res_time_in  = min_time_ff;
            res_size_in  = min_size_ff;
            res_last_in  = 1'b0;
            ret_state_in = ST_SHIFT_START;
            state_in     = ST_EMIT;
         end

         // close the gap: entries above the evicted one move down by one
         ST_SHIFT_START: begin
            if ({1'b0, min_idx_ff} == count_ff) begin
               state_in = ST_TRIM_CHK;
            end else begin
               rd_addr  = min_idx_ff + stse_pkg::idx_type'(1);
               ptr_in   = rd_addr;
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - stse_pkg::idx_type'(1);
            wr_data = rd_data;
            if ({1'b0, ptr_ff} == count_ff) begin
               state_in = ST_TRIM_CHK;
            end else begin
               rd_addr = ptr_ff + stse_pkg::idx_type'(1);
               ptr_in  = rd_addr;
            end
         end

         // wait for a free output slot; total and count are already updated
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = res_kind_ff;
               rsp_data_in.out_time    = res_time_ff;
               rsp_data_in.out_size    = res_size_ff;
               rsp_data_in.total_size  = total_ff;
               rsp_data_in.entry_count = stse_pkg::COUNT_W'(count_ff);
               rsp_data_in.last        = res_last_ff;
               state_in                = ret_state_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_state_ff <= ST_IDLE;
         capacity_ff  <= stse_pkg::CAPACITY_RESET;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_state_ff <= ret_state_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_time_ff <= new_time_in;
      new_size_ff <= new_size_in;
      ptr_ff      <= ptr_in;
      scan_idx_ff <= scan_idx_in;
      min_idx_ff  <= min_idx_in;
      min_size_ff <= min_size_in;
      min_time_ff <= min_time_in;
      res_kind_ff <= res_kind_in;
      res_time_ff <= res_time_in;
      res_size_ff <= res_size_in;
      res_last_ff <= res_last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

### test/stse_tb_pkg.sv
package stse_tb_pkg;
   import stse_pkg::*;

   // Tracks the sorted table and predicts every result the block owes.
   class eviction_scoreboard;
      logic [TIME_W-1:0]  held_times[$];
      logic [SIZE_W-1:0]  held_sizes[$];
      logic [TOTAL_W-1:0] held_total;
      logic [TOTAL_W-1:0] capacity;
      rsp_payload_type    awaited_reports[$];
      int                 failures;

      function new();
         held_total = '0;
         capacity   = CAPACITY_RESET;
         failures   = 0;
      endfunction

      function void set_capacity(logic [TOTAL_W-1:0] value);
         capacity = value;
      endfunction

      function void push_report(kind_type kind, logic [TIME_W-1:0] stamp,
                                logic [SIZE_W-1:0] size, logic last);
         rsp_payload_type r;
         r.kind        = kind;
         r.out_time    = stamp;
         r.out_size    = size;
         r.total_size  = held_total;
         r.entry_count = COUNT_W'(held_times.size());
         r.last        = last;
         awaited_reports.push_back(r);
      endfunction

      function void note_request(req_payload_type item);
         logic [TOTAL_W:0]  grown;
         int                pos;
         int                low;
         logic [TIME_W-1:0] gone_time;
         logic [SIZE_W-1:0] gone_size;
         if (item.operation == OP_INSERT) begin
            grown = {1'b0, held_total} + (TOTAL_W+1)'(item.entry_size);
            // full table or total carry: nothing changes
            if (held_times.size() >= TABLE_DEPTH || grown[TOTAL_W]) begin
               push_report(KIND_REJECTED, '0, '0, 1'b1);
               return;
            end
            pos = 0;
            while (pos < held_times.size() && held_times[pos] < item.entry_time) begin
               pos++;
            end
            held_times.insert(pos, item.entry_time);
            held_sizes.insert(pos, item.entry_size);
            held_total = grown[TOTAL_W-1:0];
            push_report(KIND_INSERTED, '0, '0, 1'b1);
            return;
         end
         while (held_total > capacity && held_times.size() > 0) begin
            // smallest size, first in table order on ties
            low = 0;
            for (int i = 1; i < held_sizes.size(); i++) begin
               if (held_sizes[i] < held_sizes[low]) begin
                  low = i;
               end
            end
            gone_time = held_times[low];
            gone_size = held_sizes[low];
            held_times.delete(low);
            held_sizes.delete(low);
            held_total = held_total - TOTAL_W'(gone_size);
            push_report(KIND_EVICTED, gone_time, gone_size, 1'b0);
         end
         push_report(KIND_DONE, '0, '0, 1'b1);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual kind %0d time %0h size %0h",
                     $time, got.kind, got.out_time, got.out_size);
            failures++;
            return;
         end
         want = awaited_reports.pop_front();
         check_field("kind", 32'(want.kind), 32'(got.kind));
         check_field("out_time", want.out_time, got.out_time);
         check_field("out_size", 32'(want.out_size), 32'(got.out_size));
         check_field("total_size", 32'(want.total_size), 32'(got.total_size));
         check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
         check_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

endpackage

### test/tb_top.sv
module tb_top;
   import stse_pkg::*;
   import stse_tb_pkg::*;

   // Cycles with no handshake on any channel before the run is declared hung.
   // Worst legit gap is a full-table trim plus a receiver stall, so this leaves
   // plenty of margin.
   localparam int IDLE_LIMIT    = 2000;
   // Quiet time at the end to catch stray items.
   localparam int DRAIN_CYCLES  = 64;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 32;

   // Receiver throttle styles.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_MASK
   } ready_style_type;

   logic clock;
   logic reset;

   stse_req_if req_bus ();
   stse_rsp_if rsp_bus ();
   stse_csr_if csr_bus ();

   eviction_scoreboard board;
   int                 idle_cycles;
   int unsigned        burst_left;
   logic               sender_gaps;

   sorted_table_with_size_eviction i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one item; the sender runs in bursts with random gaps in between.
   // valid stays high across back-to-back items in a burst.
   task automatic offer_item(input op_type op, input logic [TIME_W-1:0] stamp,
                             input logic [SIZE_W-1:0] size);
      req_payload_type item;
      int unsigned     gap;
      if (burst_left == 0) begin
         gap = sender_gaps ? $urandom_range(0, 15) : 0;
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      item.operation  = op;
      item.entry_time = stamp;
      item.entry_size = size;
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold off the sender until every predicted item has come back.
   // Checked at the falling edge so the monitor has already run for the
   // rising edge.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (board.awaited_reports.size() != 0);
      @(posedge clock);
   endtask

   // Capacity changes only with the block idle.
   task automatic write_capacity(input logic [TOTAL_W-1:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // Monitor plus watchdog: all handshakes sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            board.note_request(req_bus.data);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_result(rsp_bus.data);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            board.set_capacity(csr_bus.data);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver: stretches of one throttle style at a time, including
   // stretches with no stalls at all.
   initial begin : rsp_throttle
      ready_style_type style;
      logic [7:0]      mask;
      int unsigned     span;
      rsp_bus.ready <= 1'b0;
      forever begin
         style = ready_style_type'($urandom_range(0, 3));
         mask  = 8'($urandom_range(1, 255));
         span  = $urandom_range(20, 200);
         for (int unsigned n = 0; n < span; n++) begin
            @(posedge clock);
            case (style)
               READY_ALWAYS: rsp_bus.ready <= 1'b1;
               READY_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_bus.ready <= mask[n % 8];
            endcase
         end
      end
   end

   initial begin
      logic [TOTAL_W-1:0] cap;
      int unsigned        size_top;
      logic [TIME_W-1:0]  stamp;
      logic [SIZE_W-1:0]  size;

      board       = new();
      burst_left  = 0;
      sender_gaps = 1'b1;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // Trim on an empty table: done item alone.
      offer_item(OP_TRIM, '0, '0);
      offer_item(OP_INSERT, 32'd100, 20'd10);
      // Same stamp as a stored entry: lands in front of it. Same size too,
      // so the eviction tie below is decided by table order.
      offer_item(OP_INSERT, 32'd100, 20'd10);
      offer_item(OP_INSERT, '0, '0);
      offer_item(OP_INSERT, '1, 20'd5);
      // Zero capacity: everything goes, zero-size entry first.
      write_capacity('0);
      offer_item(OP_TRIM, '1, '1);
      // Fill with max sizes; total stays just under the 24-bit ceiling.
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         offer_item(OP_INSERT, $urandom, '1);
      end
      // Table full: rejected.
      offer_item(OP_INSERT, $urandom, SIZE_W'($urandom));
      // Largest capacity: full table already fits, done only.
      write_capacity('1);
      offer_item(OP_TRIM, '0, '0);
      // Back to zero: sixteen evictions plus done, the longest answer.
      write_capacity('0);
      offer_item(OP_TRIM, '0, '0);

      // ---- random part ----
      // Each phase picks a capacity and a size scale so that trims evict
      // a fair share; the widest capacity lets the table fill up and reject.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       cap = '0;
            1:       cap = '1;
            2:       cap = TOTAL_W'($urandom_range(0, 255));
            3:       cap = TOTAL_W'($urandom_range(256, 4095));
            4:       cap = CAPACITY_RESET;
            default: cap = TOTAL_W'($urandom);
         endcase
         write_capacity(cap);
         case ($urandom_range(0, 2))
            0:       size_top = 3;
            1:       size_top = 63;
            default: size_top = 1023;
         endcase
         sender_gaps = ($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
               // trim ignores the entry fields; keep them noisy
               offer_item(OP_TRIM, $urandom, SIZE_W'($urandom));
            end else begin
               // narrow stamps give plenty of equal-stamp inserts
               stamp = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 15));
               size  = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom)
                                                  : SIZE_W'($urandom_range(0, size_top));
               offer_item(OP_INSERT, stamp, size);
            end
         end
      end

      // A missing item stalls the drain below and trips the watchdog.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
